>>> src/scsm_pkg.sv
// Shared types, codes and constants for the sensor calibrated servo mapper.
// No dependencies; every other file of the block imports this package.
package scsm_pkg;

    localparam int DEF_SAMPLES_PER_AVERAGE = 10;
    localparam int ADC_BITS   = 10;
    localparam int LEVEL_W    = 10;
    localparam int BORDER_W   = 11;
    localparam int POS_W      = 8;
    localparam int BYTE_W     = 8;

    localparam logic [BORDER_W-1:0] CAL_LOW_START   = 11'd1024;
    localparam logic [BORDER_W-1:0] MIN_INIT_RESET  = 11'd0;
    localparam logic [BORDER_W-1:0] MAX_INIT_RESET  = 11'd1023;
    localparam logic [POS_W-1:0]    OPEN_POS_RESET  = 8'd0;
    localparam logic [POS_W-1:0]    CLOSE_POS_RESET = 8'd180;
    localparam logic [BYTE_W-1:0]   SPEED_MIN_RESET = 8'd0;
    localparam logic [BYTE_W-1:0]   SPEED_MAX_RESET = 8'd255;
    localparam int LED_FULL   = 255;
    localparam int POS_LIMIT  = 180;
    localparam int SPEED_FULL = 255;

    // iterative divider operand widths
    localparam int DIV_NUM_W = 27;
    localparam int DIV_DEN_W = 11;

    // command codes
    localparam logic [1:0] CMD_SAMPLE    = 2'd0;
    localparam logic [1:0] CMD_CAL_START = 2'd1;
    localparam logic [1:0] CMD_CAL_END   = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_MIN_INIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_MAX_INIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_POS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_POS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX       = 3'd5;

    typedef struct packed {
        logic [1:0]          command;
        logic [ADC_BITS-1:0] sample;
    } sample_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] sensor_level;
        logic [BYTE_W-1:0]  led_red;
        logic [BYTE_W-1:0]  led_green;
        logic [POS_W-1:0]   position;
        logic [BYTE_W-1:0]  speed;
        logic               drive;
        logic               range_fault;
    } result_item_t;

    typedef enum logic [1:0] {
        DIV_AVG,
        DIV_GREEN,
        DIV_POS,
        DIV_SPEED
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG,
        ST_MUL1,
        ST_GRN_START,
        ST_GRN_WAIT,
        ST_POS_START,
        ST_POS_WAIT,
        ST_MUL2,
        ST_SPD_START,
        ST_SPD_WAIT,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic     take;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_latch;
        logic     mul1;
        logic     mul2;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic group_done;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

>>> src/scsm_divider.sv
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on scsm_pkg for operand widths.
module scsm_divider
    import scsm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(DIV_NUM_W);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(DIV_NUM_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_NUM_W-1:0] quot_reg, quot_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[DIV_NUM_W-1]};
        fits      = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_TOP;
            rem_next  = '0;
            den_next  = den;
            quot_next = num;
        end
        else if (busy_reg)
        begin
            // shift in next numerator bit, subtract when it fits
            rem_next  = fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            quot_next = {quot_reg[DIV_NUM_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

>>> src/scsm_datapath.sv
// Datapath: sample accumulator, borders, configuration, multipliers, sign
// handling and the result register. Uses scsm_pkg and scsm_divider.
module scsm_datapath
    import scsm_pkg::*;
#(
    parameter int SAMPLES_PER_AVERAGE = DEF_SAMPLES_PER_AVERAGE
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  sample_item_t          sample_data,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_item_t          result_data
);

    localparam int SUM_MAX = SAMPLES_PER_AVERAGE * ((1 << ADC_BITS) - 1);
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam int CNT_W   = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
    localparam logic [CNT_W-1:0]     CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);

    // average by reciprocal: ceil(2^REC_SH / N), exact for any sum below 2^SUM_W
    localparam int REC_SH = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int REC_W  = SUM_W + 1;
    localparam logic [REC_W-1:0] REC_MUL =
        REC_W'(((1 << REC_SH) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);

    localparam int MAG1_W = 19;  // |(x-lo)*span| <= 2047*255
    localparam int Q1_W   = 20;  // signed quotient of the first maps
    localparam int Q2_W   = 28;  // signed quotient of the speed map

    // control state
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [BORDER_W-1:0] border_low_reg, border_low_next;
    logic [BORDER_W-1:0] border_high_reg, border_high_next;
    logic                calibrating_reg, calibrating_next;
    logic [POS_W-1:0]    open_pos_reg, close_pos_reg;
    logic [BYTE_W-1:0]   speed_min_reg, speed_max_reg;
    logic                result_valid_reg;

    // payload
    logic [SUM_W-1:0]     group_sum_reg;
    logic [LEVEL_W-1:0]   avg_reg;
    logic [MAG1_W-1:0]    grn_mag_reg, pos_mag_reg;
    logic                 grn_neg_reg, pos_neg_reg;
    logic [DIV_DEN_W-1:0] den_mag_reg;
    logic                 fault_reg;
    logic signed [Q1_W-1:0] q_green_reg, q_pos_reg;
    logic [DIV_NUM_W-1:0] spd_mag_reg;
    logic                 spd_neg_reg;
    logic [POS_W-1:0]     spd_den_mag_reg;
    logic                 spd_den_zero_reg;
    logic signed [Q2_W-1:0] q_spd_reg;
    result_item_t         result_reg;

    logic [SUM_W-1:0]     sum_plus;
    logic                 is_sample;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;
    logic [SUM_W+REC_W-1:0] avg_prod;
    logic [LEVEL_W-1:0]   q_avg;

    scsm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign is_sample = (sample_data.command == CMD_SAMPLE);
    assign sum_plus  = sum_reg + SUM_W'(sample_data.sample);
    assign avg_prod  = group_sum_reg * REC_MUL;
    assign q_avg     = avg_prod[REC_SH +: LEVEL_W];

    assign status.group_done = is_sample && (count_reg == CNT_LAST);
    assign status.div_done   = div_done;
    assign status.out_free   = !result_valid_reg || !result_stall;

    // accumulator, borders and calibration flag
    always_comb
    begin
        sum_next         = sum_reg;
        count_next       = count_reg;
        border_low_next  = border_low_reg;
        border_high_next = border_high_reg;
        calibrating_next = calibrating_reg;
        if (cfg_we && cfg_index == CFG_SENSOR_MIN_INIT)
            border_low_next = cfg_data;
        else if (cfg_we && cfg_index == CFG_SENSOR_MAX_INIT)
            border_high_next = cfg_data;
        else if (cmd.take)
        begin
            priority case (sample_data.command)
                CMD_CAL_START:
                begin
                    border_low_next  = CAL_LOW_START;
                    border_high_next = '0;
                    calibrating_next = 1'b1;
                    sum_next         = '0;
                    count_next       = '0;
                end
                CMD_CAL_END:
                    calibrating_next = 1'b0;
                CMD_SAMPLE:
                begin
                    if (count_reg == CNT_LAST)
                    begin
                        sum_next   = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        sum_next   = sum_plus;
                        count_next = count_reg + 1'b1;
                    end
                end
                default:
                    ;
            endcase
        end
        else if (cmd.div_latch && cmd.div_sel == DIV_AVG && calibrating_reg)
        begin
            // new average widens the calibrated range
            if ({1'b0, q_avg} < border_low_reg)
                border_low_next = {1'b0, q_avg};
            else if ({1'b0, q_avg} > border_high_reg)
                border_high_next = {1'b0, q_avg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg         <= '0;
            count_reg       <= '0;
            border_low_reg  <= MIN_INIT_RESET;
            border_high_reg <= MAX_INIT_RESET;
            calibrating_reg <= 1'b0;
            open_pos_reg    <= OPEN_POS_RESET;
            close_pos_reg   <= CLOSE_POS_RESET;
            speed_min_reg   <= SPEED_MIN_RESET;
            speed_max_reg   <= SPEED_MAX_RESET;
        end
        else
        begin
            sum_reg         <= sum_next;
            count_reg       <= count_next;
            border_low_reg  <= border_low_next;
            border_high_reg <= border_high_next;
            calibrating_reg <= calibrating_next;
            if (cfg_we)
            begin
                priority case (cfg_index)
                    CFG_OPEN_POS:  open_pos_reg  <= cfg_data[POS_W-1:0];
                    CFG_CLOSE_POS: close_pos_reg <= cfg_data[POS_W-1:0];
                    CFG_SPEED_MIN: speed_min_reg <= cfg_data[BYTE_W-1:0];
                    CFG_SPEED_MAX: speed_max_reg <= cfg_data[BYTE_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    // divider operand select
    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_GREEN:
            begin
                div_num = DIV_NUM_W'(grn_mag_reg);
                div_den = den_mag_reg;
            end
            DIV_POS:
            begin
                div_num = DIV_NUM_W'(pos_mag_reg);
                div_den = den_mag_reg;
            end
            DIV_SPEED:
            begin
                div_num = spd_mag_reg;
                div_den = DIV_DEN_W'(spd_den_mag_reg);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    // first products: (x-lo)*255 and (x-lo)*(close-open)
    logic signed [11:0] diff_x, rng;
    logic signed [8:0]  pos_span, spd_span;
    logic signed [19:0] p_green;
    logic signed [20:0] p_pos;
    logic signed [29:0] p_spd;
    logic signed [Q1_W-1:0] q1_mag;
    logic signed [Q2_W-1:0] q2_mag;

    assign diff_x   = $signed({2'b00, avg_reg}) - $signed({1'b0, border_low_reg});
    assign rng      = $signed({1'b0, border_high_reg}) - $signed({1'b0, border_low_reg});
    assign pos_span = $signed({1'b0, close_pos_reg}) - $signed({1'b0, open_pos_reg});
    assign spd_span = $signed({1'b0, speed_max_reg}) - $signed({1'b0, speed_min_reg});
    assign p_green  = ($signed(20'(diff_x)) <<< 8) - 20'(diff_x);
    assign p_pos    = diff_x * pos_span;
    assign p_spd    = q_pos_reg * spd_span;
    assign q1_mag   = $signed({1'b0, div_quot[MAG1_W-1:0]});
    assign q2_mag   = $signed({1'b0, div_quot});

    always_ff @(posedge clk)
    begin
        if (cmd.take && status.group_done)
            group_sum_reg <= sum_plus;
        if (cmd.div_latch)
        begin
            unique case (cmd.div_sel)
                DIV_AVG:   avg_reg <= q_avg;
                DIV_GREEN: q_green_reg <= fault_reg ? '0 : (grn_neg_reg ? -q1_mag : q1_mag);
                DIV_POS:   q_pos_reg   <= fault_reg ? '0 : (pos_neg_reg ? -q1_mag : q1_mag);
                DIV_SPEED: q_spd_reg   <= spd_den_zero_reg ? '0 :
                                          (spd_neg_reg ? -q2_mag : q2_mag);
                default:   ;
            endcase
        end
        if (cmd.mul1)
        begin
            grn_mag_reg <= MAG1_W'(p_green[19] ? -p_green : p_green);
            pos_mag_reg <= MAG1_W'(p_pos[20] ? -p_pos : p_pos);
            grn_neg_reg <= p_green[19] ^ rng[11];
            pos_neg_reg <= p_pos[20] ^ rng[11];
            den_mag_reg <= DIV_DEN_W'(rng[11] ? -rng : rng);
            fault_reg   <= (rng == '0);
        end
        if (cmd.mul2)
        begin
            spd_mag_reg      <= DIV_NUM_W'(p_spd[29] ? -p_spd : p_spd);
            spd_neg_reg      <= p_spd[29] ^ pos_span[8];
            spd_den_mag_reg  <= POS_W'(pos_span[8] ? -pos_span : pos_span);
            spd_den_zero_reg <= (pos_span == '0);
        end
    end

    // final sums and saturation
    logic signed [20:0] green_v, red_v, pos_v;
    logic signed [28:0] spd_v;

    assign green_v = 21'(q_green_reg);
    assign red_v   = 21'(LED_FULL) - 21'(q_green_reg);
    assign pos_v   = 21'(q_pos_reg) + $signed({13'd0, open_pos_reg});
    assign spd_v   = 29'(q_spd_reg) + $signed({21'd0, speed_min_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_reg.sensor_level <= avg_reg;
            result_reg.led_green    <= green_v < 0 ? '0 :
                                       green_v > 21'sd255 ? BYTE_W'(LED_FULL) : green_v[7:0];
            result_reg.led_red      <= red_v < 0 ? '0 :
                                       red_v > 21'sd255 ? BYTE_W'(LED_FULL) : red_v[7:0];
            result_reg.position     <= pos_v < 0 ? '0 :
                                       pos_v > 21'sd180 ? POS_W'(POS_LIMIT) : pos_v[7:0];
            result_reg.speed        <= spd_v < 0 ? '0 :
                                       spd_v > 29'sd255 ? BYTE_W'(SPEED_FULL) : spd_v[7:0];
            result_reg.drive        <= (q_pos_reg > 0);
            result_reg.range_fault  <= fault_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.load_out)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule

>>> src/scsm_ctrl.sv
// Controller state machine: sequences averaging, products and divisions.
// Depends on scsm_pkg for state, command and status types.
module scsm_ctrl
    import scsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        sample_stall  = 1'b1;
        cmd.take      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_sel   = DIV_AVG;
        cmd.div_latch = 1'b0;
        cmd.mul1      = 1'b0;
        cmd.mul2      = 1'b0;
        cmd.load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    cmd.take = 1'b1;
                    if (status.group_done)
                        state_next = ST_AVG;
                end
            end
            ST_AVG:
            begin
                // average comes straight from the reciprocal product
                cmd.div_latch = 1'b1;
                state_next    = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_GRN_START;
            end
            ST_GRN_START:
            begin
                cmd.div_sel   = DIV_GREEN;
                cmd.div_start = 1'b1;
                state_next    = ST_GRN_WAIT;
            end
            ST_GRN_WAIT:
            begin
                cmd.div_sel = DIV_GREEN;
                if (status.div_done)
                begin
                    cmd.div_latch = 1'b1;
                    state_next    = ST_POS_START;
                end
            end
            ST_POS_START:
            begin
                cmd.div_sel   = DIV_POS;
                cmd.div_start = 1'b1;
                state_next    = ST_POS_WAIT;
            end
            ST_POS_WAIT:
            begin
                cmd.div_sel = DIV_POS;
                if (status.div_done)
                begin
                    cmd.div_latch = 1'b1;
                    state_next    = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_SPD_START;
            end
            ST_SPD_START:
            begin
                cmd.div_sel   = DIV_SPEED;
                cmd.div_start = 1'b1;
                state_next    = ST_SPD_WAIT;
            end
            ST_SPD_WAIT:
            begin
                cmd.div_sel = DIV_SPEED;
                if (status.div_done)
                begin
                    cmd.div_latch = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

>>> src/sensor_calibrated_servo_mapper_top.sv
// Top level of the sensor calibrated servo mapper: controller plus datapath.
// Depends on scsm_pkg, scsm_ctrl, scsm_datapath (and scsm_divider below it).
//
//  channel   direction  handshake            payload
//  sample    in         sample_valid/stall   sample_data  (sample_item_t)
//  result    out        result_valid/stall   result_data  (result_item_t)
//  cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Commands and non-final samples are taken in the idle state. The sample that
// closes a group of SAMPLES_PER_AVERAGE is averaged by a reciprocal multiply,
// then makes three passes (load, 27 quotient steps, latch) through the
// shared bit-serial divider: LED map, position map, speed map. With two
// product steps and the output load, that item holds the sample side until
// its result is loaded, which waits while the result register is still held.
// Reset is asynchronous, active low, and restores the register defaults.
// A waiting result sits in the output register and does not block intake;
// only the next completed group waits for the result side to drain.
module sensor_calibrated_servo_mapper_top
    import scsm_pkg::*;
#(
    parameter int SAMPLES_PER_AVERAGE = DEF_SAMPLES_PER_AVERAGE
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  sample_item_t          sample_data,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_item_t          result_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // registers are plain flops, so writes always land
    assign cfg_ready = 1'b1;

    scsm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    scsm_datapath #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_data  (sample_data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for sensor_calibrated_servo_mapper_top.
// Depends on scsm_pkg and the block's RTL; predicts result items internally or takes them from the directed table.
`timescale 1ns / 100ps

module testbench;
    import scsm_pkg::*;

    localparam int GROUP        = DEF_SAMPLES_PER_AVERAGE;
    localparam int LEVEL_MAX    = (1 << LEVEL_W) - 1;
    localparam int SAMPLE_MAX   = (1 << ADC_BITS) - 1;
    localparam int BORDER_MAX   = 1024;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 150;
    localparam int DRAIN_CYCLES = 8;     // settle time for trailing commands and partial groups
    localparam int TAIL_CYCLES  = 200;   // > one full group pass through the divider
    localparam int QUIET_LIMIT  = 5000;  // cycles with no item moving anywhere
    localparam int HOLD_CYCLES  = 600;   // long result-side hold-off
    localparam int HOLD_AFTER   = 20;    // results seen before the hold-off starts
    localparam int STEADY_FROM  = 600;   // item window with no idling on either side
    localparam int STEADY_TO    = 800;
    localparam int MAX_REPORTS  = 10;

    // Code the block must ignore; not part of the package.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // ---------------------------------------------------------------------
    // Clock, reset and block ports. Every input has a known value at time 0.
    // ---------------------------------------------------------------------
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    sample_item_t          sample_data  = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_item_t          result_data;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    sensor_calibrated_servo_mapper_top #(
        .SAMPLES_PER_AVERAGE(GROUP)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ---------------------------------------------------------------------
    // Shadow of the block: accumulator, borders, calibration flag and the
    // six configuration registers, all at the block's widths.
    // ---------------------------------------------------------------------
    logic [13:0]         acc_sum;
    logic [3:0]          acc_count;
    logic [BORDER_W-1:0] border_low;
    logic [BORDER_W-1:0] border_high;
    logic                calibrating;
    logic [BORDER_W-1:0] min_init;
    logic [BORDER_W-1:0] max_init;
    logic [POS_W-1:0]    open_pos;
    logic [POS_W-1:0]    close_pos;
    logic [BYTE_W-1:0]   speed_lo;
    logic [BYTE_W-1:0]   speed_hi;

    result_item_t expected_results [$];

    int error_count  = 0;
    int results_seen = 0;
    int items_sent   = 0;
    int hold_left    = 0;
    bit held         = 1'b0;
    bit steady       = 1'b0;

    typedef struct {
        sample_item_t item;
        int           reps;
        bit           typed;   // want holds the result read straight off the spec
        result_item_t want;
    } directed_row_t;

    function automatic void report_error(input string msg);
        if (error_count < MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endfunction

    function automatic string show(input result_item_t r);
        return $sformatf("level=%0d red=%0d green=%0d pos=%0d speed=%0d drive=%0b fault=%0b",
                         r.sensor_level, r.led_red, r.led_green, r.position, r.speed,
                         r.drive, r.range_fault);
    endfunction

    function automatic bit same_result(input result_item_t a, input result_item_t b);
        return a.sensor_level === b.sensor_level && a.led_red === b.led_red &&
               a.led_green === b.led_green && a.position === b.position &&
               a.speed === b.speed && a.drive === b.drive &&
               a.range_fault === b.range_fault;
    endfunction

    // Linear map with division truncated toward zero; a flat input span
    // collapses to c, the start of the output span.
    function automatic longint span_map(input longint x, input longint a, input longint b,
                                        input longint c, input longint d);
        if (a == b)
            return c;
        return (x - a) * (d - c) / (b - a) + c;
    endfunction

    function automatic longint clip(input longint v, input longint hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the shadow by one accepted item; produced is set when the
    // item closes a group and a result item is due.
    task automatic track_item(input sample_item_t it, output bit produced,
                              output result_item_t r);
        longint avg;
        longint lo;
        longint hi;
        longint pos;
        longint spd;
        produced = 1'b0;
        r        = '0;
        case (it.command)
            CMD_CAL_START:
            begin
                border_low  = CAL_LOW_START;
                border_high = '0;
                calibrating = 1'b1;
                acc_sum     = '0;
                acc_count   = '0;
            end
            CMD_CAL_END:
                calibrating = 1'b0;
            CMD_SAMPLE:
            begin
                acc_sum   = acc_sum + it.sample;
                acc_count = acc_count + 1'b1;
                if (acc_count == 4'(GROUP))
                begin
                    avg       = longint'(acc_sum) / GROUP;
                    acc_sum   = '0;
                    acc_count = '0;
                    // borders move first, the maps see the new ones
                    if (calibrating)
                    begin
                        if (avg < longint'(border_low))
                            border_low = BORDER_W'(avg);
                        else if (avg > longint'(border_high))
                            border_high = BORDER_W'(avg);
                    end
                    lo  = longint'(border_low);
                    hi  = longint'(border_high);
                    pos = span_map(avg, lo, hi, longint'(open_pos), longint'(close_pos));
                    spd = span_map(pos, longint'(open_pos), longint'(close_pos),
                                   longint'(speed_lo), longint'(speed_hi));
                    r.sensor_level = LEVEL_W'(clip(avg, LEVEL_MAX));
                    r.led_red      = BYTE_W'(clip(span_map(avg, lo, hi, LED_FULL, 0), LED_FULL));
                    r.led_green    = BYTE_W'(clip(span_map(avg, lo, hi, 0, LED_FULL), LED_FULL));
                    r.position     = POS_W'(clip(pos, POS_LIMIT));
                    r.speed        = BYTE_W'(clip(spd, SPEED_FULL));
                    r.drive        = (pos > longint'(open_pos));
                    r.range_fault  = (lo == hi);
                    produced       = 1'b1;
                end
            end
            default:
                ;
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Sample side. Offer an item, hold it until taken, then track it and
    // queue its result. Outside the steady window, about 27 of 100 items are followed by a gap.
    // ---------------------------------------------------------------------
    task automatic send_item(input sample_item_t it, input bit typed,
                             input result_item_t want);
        bit           produced;
        bit           ignored;
        result_item_t predicted;
        sample_valid <= 1'b1;
        sample_data  <= it;
        do
            @(posedge clk);
        while (sample_stall);
        ignored = (it.command == CMD_UNUSED) || (it.command == CMD_CAL_END && !calibrating);
        track_item(it, produced, predicted);
        if (produced)
            expected_results.push_back(typed ? want : predicted);
        if (!ignored)
            items_sent++;
        steady <= (items_sent >= STEADY_FROM && items_sent < STEADY_TO);
        if (!steady && $urandom_range(99) < 27)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(($urandom_range(9) == 0) ? 20 : 3, 1))
                @(posedge clk);
        end
    endtask

    function automatic sample_item_t make_item(input logic [1:0] cmd,
                                               input logic [ADC_BITS-1:0] smp);
        sample_item_t it;
        it.command = cmd;
        it.sample  = smp;
        return it;
    endfunction

    // Sample near base; one in ten lands on a rail.
    function automatic logic [ADC_BITS-1:0] draw_sample(input int base, input int spread);
        int v;
        if ($urandom_range(9) == 0)
            return ($urandom_range(1) == 1) ? ADC_BITS'(SAMPLE_MAX) : '0;
        v = base + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return ADC_BITS'(v);
    endfunction

    // One full group of samples around a random level.
    task automatic send_group();
        int base;
        int spread;
        base = $urandom_range(SAMPLE_MAX);
        case ($urandom_range(3))
            0:       spread = 0;
            1:       spread = 16;
            2:       spread = 128;
            default: spread = SAMPLE_MAX;
        endcase
        repeat (GROUP)
            send_item(make_item(CMD_SAMPLE, draw_sample(base, spread)), 1'b0, '0);
    endtask

    // ---------------------------------------------------------------------
    // Configuration side. Writes only while the block is idle.
    // ---------------------------------------------------------------------
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SENSOR_MIN_INIT:
            begin
                min_init   = BORDER_W'(value);
                border_low = min_init;     // border reloads on write
            end
            CFG_SENSOR_MAX_INIT:
            begin
                max_init    = BORDER_W'(value);
                border_high = max_init;
            end
            CFG_OPEN_POS:  open_pos  = POS_W'(value);
            CFG_CLOSE_POS: close_pos = POS_W'(value);
            CFG_SPEED_MIN: speed_lo  = BYTE_W'(value);
            CFG_SPEED_MAX: speed_hi  = BYTE_W'(value);
            default:       ;
        endcase
    endtask

    task automatic program_setting(input int lo_b, input int hi_b, input int open_p,
                                   input int close_p, input int s_lo, input int s_hi);
        cfg_write(CFG_SENSOR_MIN_INIT, lo_b);
        cfg_write(CFG_SENSOR_MAX_INIT, hi_b);
        cfg_write(CFG_OPEN_POS, open_p);
        cfg_write(CFG_CLOSE_POS, close_p);
        cfg_write(CFG_SPEED_MIN, s_lo);
        cfg_write(CFG_SPEED_MAX, s_hi);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_value(input int hi);
        case ($urandom_range(4))
            0:       return 0;
            1:       return hi;
            default: return int'($urandom_range(hi));
        endcase
    endfunction

    // Stop offering, wait for every queued result, then let trailing
    // commands and partial groups settle before touching registers.
    task automatic drain();
        sample_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Mostly calibration sweeps (start, a few groups, end, then plain
    // groups on the new borders); the rest is loose noise that breaks
    // group alignment and throws in stray or unused commands.
    task automatic run_phase(input int budget);
        int stop_at;
        stop_at = items_sent + budget;
        repeat ($urandom_range(2, 1))
            send_group();
        while (items_sent < stop_at)
        begin
            if ($urandom_range(9) < 7)
            begin
                send_item(make_item(CMD_CAL_START, ADC_BITS'($urandom_range(SAMPLE_MAX))),
                          1'b0, '0);
                repeat ($urandom_range(4, 1))
                    send_group();
                send_item(make_item(CMD_CAL_END, ADC_BITS'($urandom_range(SAMPLE_MAX))),
                          1'b0, '0);
                repeat ($urandom_range(3, 0))
                    send_group();
            end
            else
            begin
                repeat ($urandom_range(6, 1))
                    send_item(make_item(2'($urandom_range(3)),
                                        ADC_BITS'($urandom_range(SAMPLE_MAX))), 1'b0, '0);
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Result side: check each accepted item against the oldest expectation,
    // and drive stall. One long hold-off lets the block fill and stall its
    // input while the sample side keeps offering.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : result_side
        result_item_t want;
        if (result_valid && !result_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_error({"result with nothing expected: ", show(result_data)});
            else
            begin
                want = expected_results.pop_front();
                if (!same_result(result_data, want))
                    report_error({"mismatch expected ", show(want),
                                  " actual ", show(result_data)});
            end
        end
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else if (!held && results_seen >= HOLD_AFTER && sample_valid)
        begin
            result_stall <= 1'b1;
            hold_left = HOLD_CYCLES - 1;
            held      = 1'b1;
        end
        else if (steady)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < 27);
    end

    // Watchdog: ends the run when nothing moves on any channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Main sequence: reset, directed table, randomized phases, wind-down.
    // ---------------------------------------------------------------------
    initial
    begin : stimulus
        directed_row_t rows [7];
        int            pos_eq;

        // shadow reset values
        acc_sum     = '0;
        acc_count   = '0;
        min_init    = MIN_INIT_RESET;
        max_init    = MAX_INIT_RESET;
        border_low  = MIN_INIT_RESET;
        border_high = MAX_INIT_RESET;
        calibrating = 1'b0;
        open_pos    = OPEN_POS_RESET;
        close_pos   = CLOSE_POS_RESET;
        speed_lo    = SPEED_MIN_RESET;
        speed_hi    = SPEED_MAX_RESET;

        // full-scale group on reset borders: every map at the top end of its input
        rows[0] = '{item: '{command: CMD_SAMPLE, sample: 10'd1023}, reps: GROUP, typed: 1'b1,
                    want: '{sensor_level: 10'd1023, led_red: 8'd0, led_green: 8'd255,
                            position: 8'd180, speed: 8'd255, drive: 1'b1,
                            range_fault: 1'b0}};
        // unused code, then end while not calibrating: both ignored
        rows[1] = '{item: '{command: CMD_UNUSED, sample: 10'd1023}, reps: 1, typed: 1'b0,
                    want: '0};
        rows[2] = '{item: '{command: CMD_CAL_END, sample: 10'd0}, reps: 1, typed: 1'b0,
                    want: '0};
        // partial group that the start command must throw away
        rows[3] = '{item: '{command: CMD_SAMPLE, sample: 10'd512}, reps: 3, typed: 1'b0,
                    want: '0};
        rows[4] = '{item: '{command: CMD_CAL_START, sample: 10'd0}, reps: 1, typed: 1'b0,
                    want: '0};
        // zero group while calibrating: both borders land on 0, range fault
        rows[5] = '{item: '{command: CMD_SAMPLE, sample: 10'd0}, reps: GROUP, typed: 1'b1,
                    want: '{sensor_level: 10'd0, led_red: 8'd255, led_green: 8'd0,
                            position: 8'd0, speed: 8'd0, drive: 1'b0,
                            range_fault: 1'b1}};
        rows[6] = '{item: '{command: CMD_CAL_END, sample: 10'd0}, reps: 1, typed: 1'b0,
                    want: '0};

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            repeat (rows[i].reps)
                send_item(rows[i].item, rows[i].typed, rows[i].want);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase)
                0:  program_setting(0, 0, 0, 0, 0, 0);
                1:  program_setting(BORDER_MAX, BORDER_MAX, POS_LIMIT, POS_LIMIT,
                                    SPEED_FULL, SPEED_FULL);
                // inverted spans everywhere
                2:  program_setting(BORDER_MAX, 0, POS_LIMIT, 0, SPEED_FULL, 0);
                3:  program_setting(MIN_INIT_RESET, MAX_INIT_RESET, OPEN_POS_RESET,
                                    CLOSE_POS_RESET, SPEED_MIN_RESET, SPEED_MAX_RESET);
                // open equals close: speed pinned to its low end
                4:
                begin
                    pos_eq = pick_value(POS_LIMIT);
                    program_setting(pick_value(BORDER_MAX), pick_value(BORDER_MAX),
                                    pos_eq, pos_eq, pick_value(SPEED_FULL),
                                    pick_value(SPEED_FULL));
                end
                default:
                    program_setting(pick_value(BORDER_MAX), pick_value(BORDER_MAX),
                                    pick_value(POS_LIMIT), pick_value(POS_LIMIT),
                                    pick_value(SPEED_FULL), pick_value(SPEED_FULL));
            endcase
            run_phase(PHASE_ITEMS);
        end

        sample_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (expected_results.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_results.size()));

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
